// ===== rtl/core/lbps_pkg.sv =====
package lbps_pkg;

   localparam int LED_COUNT = 4;
   localparam int LED_OUT_W = 4;
   localparam int PAT_W = 32;
   localparam int CNT_W = 4;
   localparam int PAT_BYTES = PAT_W / 8;
   localparam int PAD_BYTES = (LED_COUNT > PAT_BYTES) ? LED_COUNT : PAT_BYTES;
   localparam int LIT_PAD_W = (LED_COUNT > LED_OUT_W) ? LED_COUNT : LED_OUT_W;
   localparam int RSP_W = 8;

   localparam logic [1:0] MODE_KEEP  = 2'd0;
   localparam logic [1:0] MODE_OFF   = 2'd1;
   localparam logic [1:0] MODE_ON    = 2'd2;
   localparam logic [1:0] MODE_BLINK = 2'd3;

   localparam logic [3:0] NIB_OFF = 4'h0;
   localparam logic [3:0] NIB_ON  = 4'hF;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef logic [LED_COUNT-1:0][1:0]       mode_vec_type;
   typedef logic [LED_COUNT-1:0][CNT_W-1:0] cnt_vec_type;
   typedef logic [LED_COUNT-1:0]            lit_type;

   typedef struct packed {
      logic             start;
      logic [PAT_W-1:0] pattern;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic rounds_zero;
   } stat_type;

   function automatic lit_type on_phase(mode_vec_type mode, cnt_vec_type cnt, lit_type lit);
      lit_type res;
      res = lit;
      for (int j = 0; j < LED_COUNT; j++) begin
         if ((mode[j] == MODE_BLINK && cnt[j] != '0) || mode[j] == MODE_ON) begin
            res[j] = 1'b1;
         end else if (mode[j] == MODE_OFF) begin
            res[j] = 1'b0;
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/led_blink_pattern_sequencer.sv =====
// led blink pattern sequencer
// req channel: one word per command. tuser = func (1 = start, 0 = tick),
//   tdata = 32-bit pattern word, used on start only
// rsp channel: exactly one word per request word. tdata[3:0] = lit state of
//   leds 1..4, tdata[4] = active, upper bits zero
// a start decodes the pattern and lights the on phase; each tick is one
//   half-period and alternates off and on phases until the rounds run out
// a request word waits in the input register until the update step takes it; its
//   result is then held in the result register, which drives rsp
// throughput: one word per cycle while rsp is taken, set by the single update
//   step between the input register and the result register
// a new request is taken while a finished result still waits on rsp
// when rsp_tready is low the result holds, the update step pauses and
//   req_tready drops once the input register is also full
// reset clears all sequence state: leds off, not active, both registers empty
module led_blink_pattern_sequencer
   import lbps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PAT_W-1:0] req_tdata,  // pattern
   input  logic             req_tuser,  // func
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // leds, active
);

   logic                 in_valid_ff, in_valid_in;
   cmd_type              in_cmd_ff, in_cmd_in;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]     out_data_ff, out_data_in;
   logic                 step;
   logic                 req_take;
   logic [LED_OUT_W-1:0] leds;
   logic                 active;
   stat_type             stat;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   lbps_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cmd    (in_cmd_ff),
      .leds   (leds),
      .active (active),
      .stat   (stat)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_cmd_in    = in_cmd_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_take) begin
         in_valid_in       = 1'b1;
         in_cmd_in.start   = req_tuser;
         in_cmd_in.pattern = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = 1'b1;
         out_data_in  = RSP_W'({active, leds});
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_cmd_ff   <= in_cmd_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_start_active: assert property (@(posedge clock) disable iff (reset)
      step && in_cmd_ff.start == FUNC_START |=> rsp_tvalid && rsp_tdata[LED_OUT_W])
      else $error("start did not report active");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !step)
      else $error("pending result overwritten");

   a_idle_rounds: assert property (@(posedge clock) disable iff (reset)
      !stat.running |-> stat.rounds_zero)
      else $error("rounds left while idle");

   a_result_active: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tdata[LED_OUT_W] == stat.running)
      else $error("reported active differs from sequence state");

endmodule

// ===== rtl/core/lbps_seq.sv =====
module lbps_seq
   import lbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  cmd_type              cmd,
   output logic [LED_OUT_W-1:0] leds,
   output logic                 active,
   output stat_type             stat
);

   mode_vec_type     mode_ff, mode_in;
   cnt_vec_type      cnt_ff, cnt_in;
   logic [CNT_W-1:0] rounds_ff, rounds_in;
   logic             on_ff, on_in;
   logic             running_ff, running_in;
   lit_type          lit_ff, lit_in;

   logic [8*PAD_BYTES-1:0] pad_word;
   logic [7:0]             byte_v;
   logic [CNT_W-1:0]       most;
   logic [LIT_PAD_W-1:0]   lit_pad;

   always_comb begin
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      rounds_in  = rounds_ff;
      on_in      = on_ff;
      running_in = running_ff;
      lit_in     = lit_ff;
      pad_word   = (8*PAD_BYTES)'(cmd.pattern);
      byte_v     = '0;
      most       = '0;
      if (step) begin
         if (cmd.start == FUNC_START) begin
            // byte k drives led LED_COUNT-1-k
            for (int k = 0; k < LED_COUNT; k++) begin
               byte_v = pad_word[8*k +: 8];
               if (byte_v[7:4] == NIB_OFF) begin
                  mode_in[LED_COUNT-1-k] = MODE_OFF;
                  cnt_in[LED_COUNT-1-k]  = '0;
               end else if (byte_v[7:4] == NIB_ON) begin
                  mode_in[LED_COUNT-1-k] = MODE_ON;
                  cnt_in[LED_COUNT-1-k]  = '0;
               end else begin
                  mode_in[LED_COUNT-1-k] = MODE_BLINK;
                  cnt_in[LED_COUNT-1-k]  = byte_v[3:0];
                  if (byte_v[3:0] > most) begin
                     most = byte_v[3:0];
                  end
               end
            end
            rounds_in  = (most != '0) ? most : CNT_W'(1);
            running_in = 1'b1;
            lit_in     = on_phase(mode_in, cnt_in, lit_ff);
            on_in      = 1'b1;
         end else if (running_ff) begin
            if (on_ff) begin
               for (int j = 0; j < LED_COUNT; j++) begin
                  if (mode_ff[j] == MODE_BLINK && cnt_ff[j] != '0) begin
                     lit_in[j] = 1'b0;
                     cnt_in[j] = cnt_ff[j] - CNT_W'(1);
                  end
               end
               if (rounds_ff != '0) begin
                  rounds_in = rounds_ff - CNT_W'(1);
               end
               on_in = 1'b0;
            end else if (rounds_ff != '0) begin
               lit_in = on_phase(mode_ff, cnt_ff, lit_ff);
               on_in  = 1'b1;
            end else begin
               running_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         cnt_ff     <= '0;
         rounds_ff  <= '0;
         on_ff      <= 1'b0;
         running_ff <= 1'b0;
         lit_ff     <= '0;
      end else begin
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         rounds_ff  <= rounds_in;
         on_ff      <= on_in;
         running_ff <= running_in;
         lit_ff     <= lit_in;
      end
   end

   assign lit_pad          = LIT_PAD_W'(lit_in);
   assign leds             = lit_pad[LED_OUT_W-1:0];
   assign active           = running_in;
   assign stat.running     = running_ff;
   assign stat.rounds_zero = (rounds_ff == '0);

endmodule
